>>> rtl/qph_pkg.sv
package qph_pkg;

	localparam int CMD_W    = 2;
	localparam int KEY_W    = 30;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 10;
	localparam int COUNT_W  = 11;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

	// floor(k / 10) equals (k * DIV10_MAGIC) >> DIV10_SHIFT for every 32-bit k.
	localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
	localparam int          DIV10_SHIFT = 35;

endpackage

>>> rtl/qph_ram.sv
module qph_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 1024,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/qph_hash.sv
module qph_hash #(
	parameter int TABLE_SLOTS = 1024,
	localparam int AW         = $clog2(TABLE_SLOTS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [qph_pkg::KEY_W-1:0] key,
	output logic                     done,
	output logic [AW-1:0]            home
);
	import qph_pkg::*;

	localparam logic [AW:0] SLOTS_W = (AW+1)'(TABLE_SLOTS);

	// One Horner step, (acc * 31 + dig) mod TABLE_SLOTS, as five modular
	// doublings, one modular subtract of acc and one modular add of the digit.
	function automatic logic [AW-1:0] horner_step(input logic [AW-1:0] acc,
			input logic [3:0] dig);
		logic [AW:0] x;
		logic [AW:0] y;
		logic [AW:0] z;
		x = {1'b0, acc};
		for (int i = 0; i < 5; i++) begin
			x = {x[AW-1:0], 1'b0};
			if (x >= SLOTS_W) begin
				x = x - SLOTS_W;
			end
		end
		if (x >= {1'b0, acc}) begin
			y = x - {1'b0, acc};
		end else begin
			y = x + SLOTS_W - {1'b0, acc};
		end
		z = y + (AW+1)'(dig);
		if (z >= SLOTS_W) begin
			z = z - SLOTS_W;
		end
		return z[AW-1:0];
	endfunction

	logic             busy_q;
	logic             dig_vld_q;
	logic [KEY_W-1:0] k_q;
	logic [3:0]       dig_q;
	logic [AW-1:0]    acc_q;
	logic [61:0]      prod;
	logic [KEY_W-1:0] quot;
	logic [3:0]       rem;

	// Digit split: the quotient comes from a reciprocal multiply, and the
	// remainder needs only the low four bits since it is below ten.
	assign prod = k_q * DIV10_MAGIC;
	assign quot = KEY_W'(prod[61:DIV10_SHIFT]);
	assign rem  = k_q[3:0] - {quot[0], 3'b000} - {quot[2:0], 1'b0};

	assign done = busy_q && (k_q == '0) && !dig_vld_q;
	assign home = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			dig_vld_q <= 1'b0;
		end else if (start) begin
			busy_q    <= 1'b1;
			dig_vld_q <= 1'b0;
		end else if (busy_q) begin
			dig_vld_q <= (k_q != '0);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			k_q   <= key;
			acc_q <= '0;
		end else if (busy_q) begin
			if (k_q != '0) begin
				k_q   <= quot;
				dig_q <= rem;
			end
			if (dig_vld_q) begin
				acc_q <= horner_step(acc_q, dig_q);
			end
		end
	end

endmodule

>>> rtl/quadratic_probe_hash_table_unit.sv
// Lookup and insert of a nonzero key hash it, one step per decimal digit (up to 10), then
// read the key memory once per slot probed, up to the key, an empty slot or the step limit.
// Throughput: one command at a time; a clear sweeps the key memory through its write port,
// one entry per cycle. Reset: control state clears at once, then a clearing pass empties
// the key memory while req_stall stays high.
module quadratic_probe_hash_table_unit #(
	parameter int TABLE_SLOTS    = 1024,
	parameter int MAX_PROBE_STEP = 300
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [qph_pkg::CMD_W-1:0]    cmd,
	input  logic [qph_pkg::KEY_W-1:0]    key,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [qph_pkg::STATUS_W-1:0] status,
	output logic [qph_pkg::SLOT_W-1:0]   slot,
	output logic [qph_pkg::COUNT_W-1:0]  used_count
);
	import qph_pkg::*;

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam int SW = $clog2(MAX_PROBE_STEP + 3);

	localparam logic [AW:0]   SLOTS_W  = (AW+1)'(TABLE_SLOTS);
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SLOTS - 1);
	localparam logic [SW-1:0] STEP_MAX = SW'(MAX_PROBE_STEP);

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_HASH  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]          state_q;
	logic                sweep_report_q;
	logic [AW-1:0]       sweep_idx_q;
	logic [CW-1:0]       count_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [AW-1:0]       pos_q;
	logic [AW-1:0]       step_mod_q;
	logic [SW-1:0]       step_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [AW-1:0]       res_slot_q;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [COUNT_W-1:0]  used_count_q;

	logic                req_fire;
	logic                out_free;
	logic                hash_start;
	logic                hash_done;
	logic [AW-1:0]       hash_home;

	logic                ram_wr_en;
	logic [AW-1:0]       ram_wr_addr;
	logic [KEY_W-1:0]    ram_wr_data;
	logic                ram_rd_en;
	logic [AW-1:0]       ram_rd_addr;
	logic [KEY_W-1:0]    ram_rd_data;

	logic                probe_hit;
	logic                probe_empty;
	logic                probe_stop;
	logic                probe_exhausted;
	logic                do_insert;
	logic [AW:0]         pos_sum;
	logic [AW-1:0]       pos_next;
	logic [AW:0]         step_mod_sum;
	logic [AW-1:0]       step_mod_next;

	// A new transaction is taken only when the sequencer is idle. The result register is
	// separate, so a finished result may still wait on rsp_stall while the next command
	// is accepted.
	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// The hash unit starts for lookups and inserts with a nonzero key. A clear and the
	// invalid key zero bypass it.
	assign hash_start = req_fire && (cmd != CMD_CLEAR) && (key != '0);

	qph_hash #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (key),
		.done   (hash_done),
		.home   (hash_home)
	);

	// Probe evaluation. The read data of the key memory is valid in S_CHECK for the slot
	// held in pos_q. The probe stops at the key itself or at an empty slot.
	assign probe_hit       = (ram_rd_data == key_q);
	assign probe_empty     = (ram_rd_data == '0);
	assign probe_stop      = probe_hit || probe_empty;
	assign probe_exhausted = !probe_stop && (step_q > STEP_MAX);
	assign do_insert       = (state_q == S_CHECK) && probe_stop && probe_empty &&
	                         (cmd_q == CMD_INSERT);

	// Next probe position. The step is tracked modulo the table size alongside its true
	// value, so each position update needs one compare and subtract.
	assign pos_sum       = {1'b0, pos_q} + {1'b0, step_mod_q};
	assign pos_next      = (pos_sum >= SLOTS_W) ? AW'(pos_sum - SLOTS_W) : pos_sum[AW-1:0];
	assign step_mod_sum  = {1'b0, step_mod_q} + (AW+1)'(2);
	assign step_mod_next = (step_mod_sum >= SLOTS_W) ? AW'(step_mod_sum - SLOTS_W)
	                                                 : step_mod_sum[AW-1:0];

	// Key memory ports. Reads start at the home slot and follow the probe sequence; the
	// write port serves both the clearing pass and the store of a newly inserted key.
	// A write and a read never fall into the same cycle, and every read comes in a later
	// cycle than the last write, so no forwarding is needed.
	assign ram_rd_en   = ((state_q == S_HASH) && hash_done) ||
	                     ((state_q == S_CHECK) && !probe_stop && !probe_exhausted);
	assign ram_rd_addr = (state_q == S_HASH) ? hash_home : pos_next;
	assign ram_wr_en   = (state_q == S_SWEEP) || do_insert;
	assign ram_wr_addr = (state_q == S_SWEEP) ? sweep_idx_q : pos_q;
	assign ram_wr_data = (state_q == S_SWEEP) ? '0 : key_q;

	qph_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_SLOTS)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Sequencer and occupancy count. After reset the sequencer sweeps the memory without
	// reporting; a clear command sweeps it and then reports.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_SWEEP;
			sweep_report_q <= 1'b0;
			sweep_idx_q    <= '0;
			count_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (cmd == CMD_CLEAR) begin
							state_q        <= S_SWEEP;
							sweep_report_q <= 1'b1;
							sweep_idx_q    <= '0;
						end else if (key == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (hash_done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (probe_stop || probe_exhausted) begin
						state_q <= S_DONE;
					end
					if (do_insert) begin
						count_q <= count_q + CW'(1);
					end
				end
				S_SWEEP: begin
					sweep_idx_q <= sweep_idx_q + AW'(1);
					if (sweep_idx_q == LAST_IDX) begin
						count_q <= '0;
						state_q <= sweep_report_q ? S_DONE : S_IDLE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command context and probe registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q      <= cmd;
			key_q      <= key;
			res_slot_q <= '0;
			if (cmd == CMD_CLEAR) begin
				res_status_q <= ST_CLEARED;
			end else begin
				res_status_q <= ST_INVALID;
			end
		end
		if ((state_q == S_HASH) && hash_done) begin
			pos_q      <= hash_home;
			step_q     <= SW'(1);
			step_mod_q <= AW'(1);
		end
		if (state_q == S_CHECK) begin
			if (probe_stop) begin
				res_slot_q <= pos_q;
				if (cmd_q == CMD_INSERT) begin
					res_status_q <= probe_empty ? ST_INSERTED : ST_DUPLICATE;
				end else begin
					res_status_q <= probe_empty ? ST_ABSENT : ST_FOUND;
				end
			end else if (probe_exhausted) begin
				res_slot_q   <= '0;
				res_status_q <= ST_FULL;
			end else begin
				pos_q      <= pos_next;
				step_q     <= step_q + SW'(2);
				step_mod_q <= step_mod_next;
			end
		end
	end

	// Result register: loaded from S_DONE when empty or being emptied in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			status_q     <= res_status_q;
			slot_q       <= SLOT_W'(res_slot_q);
			used_count_q <= COUNT_W'(count_q);
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign slot       = slot_q;
	assign used_count = used_count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_SLOTS))
		else $error("occupancy count exceeds the table size");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_wr_en && ram_rd_en))
		else $error("key memory read and write in the same cycle");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the occupancy count");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && out_free && (res_status_q == ST_CLEARED)) |=>
		(rsp_valid && (used_count == '0)))
		else $error("clear result reports a nonzero count");
`endif

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

import qph_pkg::*;

localparam int SLOTS       = 1024;
localparam int PROBE_LIMIT = 300;

// Command code three is not defined by the block and behaves as a lookup.
localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

typedef struct packed {
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [COUNT_W-1:0]  used;
} lookup_outcome_t;

// Home slot of a key: base-31 Horner sum over its decimal digits, lowest digit first.
function automatic int unsigned home_slot(input logic [KEY_W-1:0] k);
	int unsigned acc;
	int unsigned rest;
	acc = 0;
	rest = 32'(k);
	while (rest > 0) begin
		acc = (acc * 31 + rest % 10) % SLOTS;
		rest = rest / 10;
	end
	return acc;
endfunction

class hash_table_mirror;
	bit [KEY_W-1:0]  slot_key [SLOTS];
	int unsigned     occupied;
	lookup_outcome_t awaited [$];
	int unsigned     mismatches;

	function new();
		mismatches = 0;
		wipe();
	endfunction

	function void wipe();
		for (int i = 0; i < SLOTS; i++)
			slot_key[i] = '0;
		occupied = 0;
	endfunction

	// Walks the square-offset path; returns 0 when the step limit runs out.
	function bit probe_for(input logic [KEY_W-1:0] k, output int unsigned stop);
		int unsigned pos;
		int unsigned step;
		pos = home_slot(k);
		step = 1;
		stop = 0;
		while (1) begin
			if (slot_key[pos] == k || slot_key[pos] == '0) begin
				stop = pos;
				return 1'b1;
			end
			if (step > PROBE_LIMIT)
				return 1'b0;
			pos = (pos + step) % SLOTS;
			step = step + 2;
		end
		return 1'b0;
	endfunction

	function void note_command(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k);
		lookup_outcome_t r;
		int unsigned     stop;
		stop = 0;
		if (c == CMD_CLEAR) begin
			wipe();
			r.status = ST_CLEARED;
		end else if (k == '0) begin
			r.status = ST_INVALID;
		end else if (!probe_for(k, stop)) begin
			stop = 0;
			r.status = ST_FULL;
		end else if (c == CMD_INSERT) begin
			if (slot_key[stop] != '0) begin
				r.status = ST_DUPLICATE;
			end else begin
				slot_key[stop] = k;
				occupied++;
				r.status = ST_INSERTED;
			end
		end else begin
			r.status = (slot_key[stop] != '0) ? ST_FOUND : ST_ABSENT;
		end
		r.slot = SLOT_W'(stop);
		r.used = COUNT_W'(occupied);
		awaited.push_back(r);
	endfunction

	task report(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task check_result(input logic [STATUS_W-1:0] st, input logic [SLOT_W-1:0] sl,
			input logic [COUNT_W-1:0] uc);
		lookup_outcome_t want;
		if (awaited.size() == 0) begin
			report($sformatf("result with nothing outstanding: status %0d slot %0d used %0d",
				st, sl, uc));
			return;
		end
		want = awaited.pop_front();
		if (st !== want.status)
			report($sformatf("status %0d, predicted %0d", st, want.status));
		if (sl !== want.slot)
			report($sformatf("slot %0d, predicted %0d", sl, want.slot));
		if (uc !== want.used)
			report($sformatf("used_count %0d, predicted %0d", uc, want.used));
	endtask

	function int unsigned pending();
		return awaited.size();
	endfunction
endclass

module testbench;

	// Long receiver hold-offs: where they start (in accepted transactions) and how long
	// they last. The block works on one command at a time, so a hold this long backs it
	// up and forces req_stall high while the sender keeps offering.
	localparam int unsigned HOLD_MARK_A = 350;
	localparam int unsigned HOLD_MARK_B = 1000;
	localparam int unsigned HOLD_CYCLES = 600;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                req_valid  = 1'b0;
	logic                req_stall;
	logic [CMD_W-1:0]    cmd        = CMD_LOOKUP;
	logic [KEY_W-1:0]    key        = '0;
	logic                rsp_valid;
	logic                rsp_stall  = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [COUNT_W-1:0]  used_count;

	hash_table_mirror board;

	// Accepted request transactions; updated with nonblocking assignments only, so the
	// receiver process samples it without racing the sender.
	int unsigned accepted_count = 0;
	int unsigned hold_left      = 0;
	int unsigned holds_done     = 0;

	// Three distinct keys for every home slot, found by scanning small keys at time zero.
	// They let the stimulus build collision chains on purpose.
	bit [KEY_W-1:0] homed_key   [SLOTS][3];
	int unsigned    homed_count [SLOTS];

	// Keys inserted lately, reused so that lookups hit and inserts hit duplicates.
	logic [KEY_W-1:0] recent_keys [$];

	quadratic_probe_hash_table_unit #(
		.TABLE_SLOTS    (SLOTS),
		.MAX_PROBE_STEP (PROBE_LIMIT)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.cmd        (cmd),
		.key        (key),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.slot       (slot),
		.used_count (used_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Pacing runs in three phases by accepted count: first the sender idles with odds of
	// 30 in a hundred and the receiver stalls with odds of 48 in a hundred, then the other
	// way round, and at the end neither side idles.
	function automatic int unsigned pacing_phase();
		if (accepted_count < 450)
			return 0;
		else if (accepted_count < 900)
			return 1;
		return 2;
	endfunction

	// Response side. A result transaction completes at an edge with rsp_valid high and
	// rsp_stall low; the values seen here are the ones from before the edge.
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			board.check_result(status, slot, used_count);
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (holds_done < 2 &&
				accepted_count >= (holds_done == 0 ? HOLD_MARK_A : HOLD_MARK_B)) begin
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
			rsp_stall <= 1'b1;
		end else begin
			case (pacing_phase())
				0: rsp_stall <= ($urandom_range(0, 99) < 48);
				1: rsp_stall <= ($urandom_range(0, 99) < 30);
				default: rsp_stall <= 1'b0;
			endcase
		end
	end

	// Offers one request transaction and returns at the edge that accepts it. Called at a
	// rising edge; valid is raised or kept high with a single assignment per edge.
	task automatic issue_command(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k);
		int unsigned gap_pct;
		case (pacing_phase())
			0: gap_pct = 30;
			1: gap_pct = 48;
			default: gap_pct = 0;
		endcase
		while ($urandom_range(0, 99) < gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		cmd <= c;
		key <= k;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		board.note_command(c, k);
		accepted_count <= accepted_count + 1;
		if (c == CMD_CLEAR) begin
			recent_keys.delete();
		end else if (c == CMD_INSERT && k != '0) begin
			recent_keys.push_back(k);
			if (recent_keys.size() > 64)
				void'(recent_keys.pop_front());
		end
	endtask

	// General traffic: mostly lookups and inserts over recent keys and over keys that
	// share a few neighboring home slots, plus wide random keys (including ones above
	// the nine-digit range), key zero, the spare command and an occasional clear.
	task automatic mixed_traffic(input int unsigned count);
		int unsigned      n;
		int unsigned      roll;
		int unsigned      hot_base;
		logic [CMD_W-1:0] c;
		logic [KEY_W-1:0] k;
		hot_base = $urandom_range(0, SLOTS - 1);
		for (n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 1)
				c = CMD_CLEAR;
			else if (roll < 8)
				c = CMD_SPARE;
			else if (roll < 45)
				c = CMD_INSERT;
			else
				c = CMD_LOOKUP;
			roll = $urandom_range(0, 99);
			if (roll < 4)
				k = '0;
			else if (roll < 42 && recent_keys.size() != 0)
				k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
			else if (roll < 65)
				k = homed_key[(hot_base + $urandom_range(0, 5)) % SLOTS][$urandom_range(0, 2)];
			else if (roll < 85)
				k = KEY_W'($urandom);
			else
				k = KEY_W'($urandom_range(1, 99999));
			issue_command(c, k);
		end
	endtask

	// Fills the whole probe path of one home slot with keys homed on each slot of that
	// path, leaving one gap. A second key of the target home then walks deep to the gap,
	// and once the path is full a third key of that home exhausts the probe (table full).
	task automatic crowd_probe_path();
		int unsigned target;
		int unsigned i;
		int unsigned j;
		int unsigned pick;
		int unsigned tmp;
		int unsigned path [$];
		bit          seen;
		target = $urandom_range(0, SLOTS - 1);
		for (i = 0; i <= (PROBE_LIMIT + 1) / 2; i++) begin
			pick = (target + i * i) % SLOTS;
			seen = 1'b0;
			for (j = 0; j < path.size(); j++)
				if (path[j] == pick)
					seen = 1'b1;
			if (!seen)
				path.push_back(pick);
		end
		for (i = path.size() - 1; i > 0; i--) begin
			pick = $urandom_range(0, i);
			tmp = path[i];
			path[i] = path[pick];
			path[pick] = tmp;
		end
		issue_command(CMD_CLEAR, KEY_W'($urandom));
		// Every key lands on its own home, since the table starts empty and the homes
		// are distinct. The last slot of the shuffled path stays empty.
		for (i = 0; i + 1 < path.size(); i++)
			if (homed_key[path[i]][0] != '0)
				issue_command(CMD_INSERT, homed_key[path[i]][0]);
		issue_command(CMD_LOOKUP, homed_key[target][1]);
		issue_command(CMD_INSERT, homed_key[target][1]);
		issue_command(CMD_LOOKUP, homed_key[target][1]);
		issue_command(CMD_INSERT, homed_key[target][1]);
		issue_command(CMD_LOOKUP, homed_key[path[$urandom_range(0, path.size() - 2)]][0]);
		issue_command(CMD_LOOKUP, homed_key[target][2]);
		issue_command(CMD_INSERT, homed_key[target][2]);
		issue_command(CMD_SPARE, homed_key[target][2]);
	endtask

	initial begin
		logic [KEY_W-1:0] scan;
		int unsigned      h;
		int unsigned      filled;
		board = new();

		filled = 0;
		scan = KEY_W'(1);
		while (filled < SLOTS * 3 && scan < 3000000) begin
			h = home_slot(scan);
			if (homed_count[h] < 3) begin
				homed_key[h][homed_count[h]] = scan;
				homed_count[h]++;
				filled++;
			end
			scan++;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. Key 1 has home slot 1, and homed_key[1] holds two more keys
		// with that home, so the collision cases below land on known slots.
		issue_command(CMD_LOOKUP, KEY_W'(1));         // miss on an empty table
		issue_command(CMD_INSERT, KEY_W'(1));
		issue_command(CMD_INSERT, KEY_W'(1));         // duplicate
		issue_command(CMD_LOOKUP, KEY_W'(1));         // hit
		issue_command(CMD_SPARE, KEY_W'(1));          // spare command acts as a lookup
		issue_command(CMD_LOOKUP, '0);                // key zero is invalid
		issue_command(CMD_INSERT, '0);
		issue_command(CMD_SPARE, '0);
		issue_command(CMD_INSERT, homed_key[1][1]);   // collides, moves one slot on
		issue_command(CMD_LOOKUP, homed_key[1][1]);
		issue_command(CMD_LOOKUP, homed_key[1][2]);   // miss at the empty slot at offset four
		issue_command(CMD_INSERT, homed_key[1][2]);   // lands at offset four
		issue_command(CMD_INSERT, {KEY_W{1'b1}});     // widest key, ten digits
		issue_command(CMD_LOOKUP, {KEY_W{1'b1}});
		issue_command(CMD_INSERT, KEY_W'(999999999));
		issue_command(CMD_INSERT, 30'h2AAA_AAAA);
		issue_command(CMD_LOOKUP, 30'h1555_5555);
		issue_command(CMD_CLEAR, {KEY_W{1'b1}});      // the key field is ignored
		issue_command(CMD_LOOKUP, KEY_W'(1));
		issue_command(CMD_LOOKUP, {KEY_W{1'b1}});
		issue_command(CMD_CLEAR, '0);
		issue_command(CMD_INSERT, KEY_W'(999999999));
		issue_command(CMD_LOOKUP, KEY_W'(999999999));

		// Random part, with two crowded probe paths placed in different pacing phases.
		mixed_traffic(400);
		crowd_probe_path();
		mixed_traffic(350);
		crowd_probe_path();
		mixed_traffic(350);

		req_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		// Any stray result would show up inside this window, which outlasts the longest lookup.
		repeat (200) @(posedge clk);
		if (board.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Safety net against a hung handshake; far beyond the slowest correct run.
	initial begin
		#50000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> quadratic_probe_hash_table_unit.f
rtl/qph_pkg.sv
rtl/qph_ram.sv
rtl/qph_hash.sv
rtl/quadratic_probe_hash_table_unit.sv
sim/testbench.sv
